### hdl/accumulator_machine_step_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator machine step block.
// Each macro expands to one labeled concurrent assertion that reports through
// $error. Every property is sampled on the rising clock edge and is disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_MACHINE_STEP_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_STEP_TOP_MACROS_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define AMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define AMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ams_pkg.sv
// ----------------------------------------------------------------------------
// ams_pkg
// Opcodes, payload types and shared constants of the accumulator machine
// step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ams_pkg;

   // Instruction opcodes. Codes above OP_STOP are invalid and halt with an error.
   localparam logic [3:0] OP_INPUT  = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_ADD    = 4'd2;
   localparam logic [3:0] OP_SUB    = 4'd3;
   localparam logic [3:0] OP_MULT   = 4'd4;
   localparam logic [3:0] OP_STORE  = 4'd5;
   localparam logic [3:0] OP_OUTPUT = 4'd6;
   localparam logic [3:0] OP_JUMPZ  = 4'd7;
   localparam logic [3:0] OP_JUMPP  = 4'd8;
   localparam logic [3:0] OP_JUMPN  = 4'd9;
   localparam logic [3:0] OP_JUMP   = 4'd10;
   localparam logic [3:0] OP_STOP   = 4'd11;

   // Program counter advance of every instruction that neither branches nor stops.
   localparam int PC_STEP = 2;

   // One instruction transaction.
   typedef struct packed {
      logic [3:0]  req_type;
      logic [7:0]  operand_addr;
      logic [15:0] input_value;
   } ams_req_type;

   // One result transaction.
   typedef struct packed {
      logic [7:0]         next_pc;
      logic signed [15:0] acc_value;
      logic [15:0]        out_word;
      logic               out_valid;
      logic               halted;
      logic               bad_opcode;
   } ams_rsp_type;

   // Sticky machine status.
   typedef struct packed {
      logic halted;
      logic bad_opcode;
   } ams_flags_type;

   // Data memory write request from the execute unit.
   typedef struct packed {
      logic        en;
      logic [15:0] data;
   } ams_wr_type;

   // Word shown by an OUTPUT instruction.
   typedef struct packed {
      logic        valid;
      logic [15:0] word;
   } ams_show_type;

endpackage

`default_nettype wire

### hdl/ams_stream_if.sv
// ----------------------------------------------------------------------------
// ams_stream_if
// Valid/ready channel carrying one payload. A transaction completes at a
// rising clock edge at which valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ams_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

`default_nettype wire

### hdl/accumulator_machine_step_top.sv
// ----------------------------------------------------------------------------
// accumulator_machine_step_top
// Executes one decoded accumulator machine instruction per transaction and
// returns the machine state after it.
// ----------------------------------------------------------------------------
// Each request transaction is one instruction; each yields exactly one response
// transaction in order. An instruction's operand word is read from the
// synchronous data memory at the edge that accepts it. The instruction then
// executes into the response register once that register is empty or its
// response is being taken, and the response completes when it is taken. A
// new instruction can be accepted every cycle: the memory read
// overlaps with execution of the previous instruction, and a word written by
// that instruction is forwarded to the read. The request side stalls only while
// an instruction waits to execute behind a response that is not being taken.
// Memory words never written read as undefined. Addresses and branch targets
// wrap at MEM_DEPTH.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module accumulator_machine_step_top #(
   parameter int MEM_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   ams_stream_if.sink   req_chan,
   ams_stream_if.source rsp_chan
);

   localparam int AW = $clog2(MEM_DEPTH);

   // Reduces an 8-bit address modulo the memory depth (depth is at least 16).
   function automatic logic [AW-1:0] wrap_addr(input logic [7:0] raw);
      logic [20:0] rest;
      rest = 21'(raw);
      for (int k = 3; k >= 0; k--) begin
         if (rest >= 21'(MEM_DEPTH << k)) begin
            rest = rest - 21'(MEM_DEPTH << k);
         end
      end
      return rest[AW-1:0];
   endfunction

   logic                   req_fire;
   logic                   exec_fire;
   logic [AW-1:0]          rd_addr;

   // Read stage.
   logic                   s1_valid_ff, s1_valid_in;
   logic [3:0]             s1_op_ff;
   logic [AW-1:0]          s1_addr_ff;
   logic [15:0]            s1_value_ff;
   logic                   fwd_hit_ff;
   logic [15:0]            fwd_data_ff;
   logic [15:0]            mem_rd_ff;
   logic [15:0]            operand;

   // Machine state.
   logic [AW-1:0]          pc_ff, pc_in;
   logic [15:0]            acc_ff, acc_in;
   ams_pkg::ams_flags_type flags_ff, flags_in;
   ams_pkg::ams_wr_type    mem_wr;
   ams_pkg::ams_show_type  show;
   logic                   wr_en;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   ams_pkg::ams_rsp_type   rsp_data_ff, rsp_data_in;

   logic [15:0]            data_mem [MEM_DEPTH];

   // Handshakes.
   assign exec_fire      = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || exec_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rd_addr        = wrap_addr(req_chan.payload.operand_addr);
   assign wr_en          = exec_fire && mem_wr.en;

   // Data memory: one write port for the executing instruction, one read port
   // for the instruction being accepted.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_mem[s1_addr_ff] <= mem_wr.data;
      end
      if (req_fire) begin
         mem_rd_ff <= data_mem[rd_addr];
      end
   end

   // Read stage control.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (exec_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_fire) begin
            fwd_hit_ff <= wr_en && (s1_addr_ff == rd_addr);
         end
      end
   end

   // Read stage payload; the forwarded word covers a write in the accept cycle.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= req_chan.payload.req_type;
         s1_addr_ff  <= rd_addr;
         s1_value_ff <= req_chan.payload.input_value;
         fwd_data_ff <= mem_wr.data;
      end
   end

   assign operand = fwd_hit_ff ? fwd_data_ff : mem_rd_ff;

   ams_exec #(
      .MEM_DEPTH (MEM_DEPTH),
      .AW        (AW)
   ) u_exec (
      .op          (s1_op_ff),
      .addr        (s1_addr_ff),
      .input_value (s1_value_ff),
      .operand     (operand),
      .pc          (pc_ff),
      .acc         (acc_ff),
      .flags       (flags_ff),
      .pc_next     (pc_in),
      .acc_next    (acc_in),
      .flags_next  (flags_in),
      .mem_wr      (mem_wr),
      .show        (show)
   );

   // Architectural state commits when the instruction executes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         acc_ff   <= '0;
         flags_ff <= '0;
      end else if (exec_fire) begin
         pc_ff    <= pc_in;
         acc_ff   <= acc_in;
         flags_ff <= flags_in;
      end
   end

   // Response register.
   always_comb begin
      rsp_data_in.next_pc    = 8'(pc_in);
      rsp_data_in.acc_value  = $signed(acc_in);
      rsp_data_in.out_word   = show.word;
      rsp_data_in.out_valid  = show.valid;
      rsp_data_in.halted     = flags_in.halted;
      rsp_data_in.bad_opcode = flags_in.bad_opcode;
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/ams_exec.sv
// ----------------------------------------------------------------------------
// ams_exec
// Execute unit: computes the machine state after one instruction from the
// current state and the data memory word at the operand address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ams_exec #(
   parameter int MEM_DEPTH = 256,
   parameter int AW        = $clog2(MEM_DEPTH)
) (
   input  logic [3:0]            op,
   input  logic [AW-1:0]         addr,
   input  logic [15:0]           input_value,
   input  logic [15:0]           operand,
   input  logic [AW-1:0]         pc,
   input  logic [15:0]           acc,
   input  ams_pkg::ams_flags_type flags,
   output logic [AW-1:0]         pc_next,
   output logic [15:0]           acc_next,
   output ams_pkg::ams_flags_type flags_next,
   output ams_pkg::ams_wr_type    mem_wr,
   output ams_pkg::ams_show_type  show
);

   logic [AW:0]   pc_sum;
   logic [AW-1:0] pc_adv;
   logic [31:0]   product;
   logic          acc_zero;
   logic          acc_neg;

   // Advance by two, wrapping at the memory depth.
   assign pc_sum = {1'b0, pc} + (AW + 1)'(ams_pkg::PC_STEP);
   assign pc_adv = (pc_sum >= (AW + 1)'(MEM_DEPTH)) ?
                   AW'(pc_sum - (AW + 1)'(MEM_DEPTH)) : pc_sum[AW-1:0];

   assign product  = {16'd0, acc} * {16'd0, operand};
   assign acc_zero = (acc == 16'd0);
   assign acc_neg  = acc[15];

   // Instruction decode and next state. A halted machine ignores the instruction.
   always_comb begin
      pc_next    = pc;
      acc_next   = acc;
      flags_next = flags;
      mem_wr     = '0;
      show       = '0;
      if (!flags.halted) begin
         unique case (op)
            ams_pkg::OP_INPUT: begin
               mem_wr.en   = 1'b1;
               mem_wr.data = input_value;
               pc_next     = pc_adv;
            end
            ams_pkg::OP_LOAD: begin
               acc_next = operand;
               pc_next  = pc_adv;
            end
            ams_pkg::OP_ADD: begin
               acc_next = acc + operand;
               pc_next  = pc_adv;
            end
            ams_pkg::OP_SUB: begin
               acc_next = acc - operand;
               pc_next  = pc_adv;
            end
            ams_pkg::OP_MULT: begin
               acc_next = product[15:0];
               pc_next  = pc_adv;
            end
            ams_pkg::OP_STORE: begin
               mem_wr.en   = 1'b1;
               mem_wr.data = acc;
               pc_next     = pc_adv;
            end
            ams_pkg::OP_OUTPUT: begin
               show.valid = 1'b1;
               show.word  = operand;
               pc_next    = pc_adv;
            end
            ams_pkg::OP_JUMPZ: begin
               pc_next = acc_zero ? addr : pc_adv;
            end
            ams_pkg::OP_JUMPP: begin
               pc_next = (!acc_zero && !acc_neg) ? addr : pc_adv;
            end
            ams_pkg::OP_JUMPN: begin
               pc_next = acc_neg ? addr : pc_adv;
            end
            ams_pkg::OP_JUMP: begin
               pc_next = addr;
            end
            ams_pkg::OP_STOP: begin
               flags_next.halted = 1'b1;
            end
            default: begin
               flags_next.halted     = 1'b1;
               flags_next.bad_opcode = 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### hdl/ams_checker.sv
// ----------------------------------------------------------------------------
// ams_checker
// Port-level checks of the accumulator machine step block, bound to its top
// level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "accumulator_machine_step_top_macros.svh"

module ams_checker (
   input logic           clock,
   input logic           reset,
   ams_stream_if.sink    req_chan,
   ams_stream_if.source  rsp_chan
);

   logic rsp_fire;
   logic seen_halt_ff, seen_halt_in;

   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // Remember that a delivered response showed the machine halted.
   assign seen_halt_in = seen_halt_ff || (rsp_fire && rsp_chan.payload.halted);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else begin
         seen_halt_ff <= seen_halt_in;
      end
   end

   // A waiting response is not withdrawn.
   `AMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid, "response withdrawn while stalled")

   // Halt is sticky across transactions.
   `AMS_ASSERT_NOW(a_halt_sticky, clock, reset, rsp_chan.valid && seen_halt_ff, rsp_chan.payload.halted, "halt flag cleared after halting")

   // The error flag only comes with a halt.
   `AMS_ASSERT_NOW(a_bad_halts, clock, reset, rsp_chan.valid && rsp_chan.payload.bad_opcode, rsp_chan.payload.halted, "bad opcode without halt")

   // A shown word comes only from an executing, non-halted machine.
   `AMS_ASSERT_NOW(a_show_running, clock, reset, rsp_chan.valid && rsp_chan.payload.out_valid, !rsp_chan.payload.halted, "output shown by a halted machine")

   // Without an output instruction the word reads as zero.
   `AMS_ASSERT_NOW(a_word_zero, clock, reset, rsp_chan.valid && !rsp_chan.payload.out_valid, rsp_chan.payload.out_word == 16'd0, "output word nonzero without output")

endmodule

bind accumulator_machine_step_top ams_checker u_ams_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

`default_nettype wire
